/* design/uart_dual_ring_buffer_assert.svh */
// Assertion macros shared by the serial port ring buffer RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef UART_DUAL_RING_BUFFER_ASSERT_SVH
`define UART_DUAL_RING_BUFFER_ASSERT_SVH

`ifndef SYNTH
// Check that a condition implies another in the same cycle.
`define UDRB_ASSERT_NOW(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("udrb assertion failed");
// Check that a condition implies another in the next cycle.
`define UDRB_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("udrb assertion failed");
`else
`define UDRB_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define UDRB_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

/* design/udrb_pkg.sv */
// Types, codes and helpers for the serial port ring buffer block.
// No dependencies; used by the controller, datapath and top level.
package udrb_pkg;

  // Event codes carried by the kind field
  typedef enum logic [2:0] {
    KIND_HOST_WR  = 3'd0,
    KIND_TX_RDY   = 3'd1,
    KIND_RX_BYTE  = 3'd2,
    KIND_HOST_RD  = 3'd3,
    KIND_FLUSH_TX = 3'd4,
    KIND_FLUSH_RX = 3'd5
  } kind_t;

  // Configuration register indexes
  localparam logic CFG_TX_SIZE = 1'b0;
  localparam logic CFG_RX_SIZE = 1'b1;

  localparam logic [2:0] SIZE_LOG2_RESET = 3'd7;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DONE = 1'b1
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_valid;
  } dp_status_t;

  // One result item
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [7:0] read_byte;
    logic       write_refused;
    logic       rx_dropped;
    logic [6:0] rx_count;
    logic       tx_request;
  } result_t;

  // Result fields known at acceptance, before store data returns
  typedef struct packed {
    logic       tx_valid;
    logic       read_ok;
    logic       write_refused;
    logic       rx_dropped;
    logic [6:0] rx_count;
    logic       tx_request;
  } pend_t;

  // Index mask of a queue: zero reads as one, capped at the store depth
  function automatic logic [6:0] size_mask(input logic [2:0] lg, input logic [2:0] max_lg);
    logic [2:0] e;
    begin
      e = (lg == 3'd0) ? 3'd1 : lg;
      if (e > max_lg) e = max_lg;
      return 7'((8'd1 << e) - 8'd1);
    end
  endfunction

endpackage

/* design/udrb_in_if.sv */
// Input event channel of the serial port ring buffer.
// Carries valid, ready and the event payload; no dependencies.
interface udrb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

/* design/udrb_out_if.sv */
// Result channel of the serial port ring buffer.
// Carries valid, ready and the result fields; no dependencies.
interface udrb_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic [7:0] read_byte;
  logic       write_refused;
  logic       rx_dropped;
  logic [6:0] rx_count;
  logic       tx_request;

  modport source (output valid, output tx_valid, output tx_byte, output read_byte,
                  output write_refused, output rx_dropped, output rx_count,
                  output tx_request, input ready);
  modport sink   (input valid, input tx_valid, input tx_byte, input read_byte,
                  input write_refused, input rx_dropped, input rx_count,
                  input tx_request, output ready);
endinterface

/* design/udrb_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module udrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read; read data holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/udrb_ctrl.sv */
// Controller of the serial port ring buffer: event sequencing and result hand-off.
// Depends on udrb_pkg.
module udrb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  out_ready,
  input  udrb_pkg::dp_status_t  status,
  output logic                  in_ready,
  output udrb_pkg::ctrl_cmd_t   cmd
);

  udrb_pkg::ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= udrb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      udrb_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) state_nxt = udrb_pkg::ST_DONE;
      end
      udrb_pkg::ST_DONE: begin
        // hold the finished result until the output register frees up
        if (!status.out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = udrb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = udrb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/udrb_datapath.sv */
// Datapath of the serial port ring buffer: pointers, size registers, stores,
// pending result and output register. Depends on udrb_pkg, udrb_ram and the
// assertion header.
`include "uart_dual_ring_buffer_assert.svh"

module udrb_datapath #(
  parameter int QUEUE_DEPTH = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [2:0]           cfg_data,
  input  logic [2:0]           in_kind,
  input  logic [7:0]           in_data_byte,
  input  udrb_pkg::ctrl_cmd_t  cmd,
  input  logic                 out_ready,
  output udrb_pkg::dp_status_t status,
  output logic                 out_valid,
  output udrb_pkg::result_t    result
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam logic [2:0] MaxLog2 = 3'(PW);

  typedef logic [PW-1:0] ptr_t;

  logic [2:0] tx_lg_r, tx_lg_nxt, rx_lg_r, rx_lg_nxt;
  ptr_t tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  ptr_t rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic tx_irq_r, tx_irq_nxt;
  logic out_valid_r, out_valid_nxt;
  udrb_pkg::pend_t   pend_r, pend_nxt;
  udrb_pkg::result_t res_r, res_nxt;

  ptr_t tmask, rmask, tx_head_inc, rx_head_inc;
  logic tx_full, tx_empty, rx_full, rx_empty;
  logic tx_we, tx_re, rx_we, rx_re;
  logic [7:0] tx_rdata, rx_rdata;
  udrb_pkg::kind_t kind;

  // Queue masks and occupancy
  assign tmask       = PW'(udrb_pkg::size_mask(tx_lg_r, MaxLog2));
  assign rmask       = PW'(udrb_pkg::size_mask(rx_lg_r, MaxLog2));
  assign tx_head_inc = (tx_head_r + ptr_t'(1)) & tmask;
  assign rx_head_inc = (rx_head_r + ptr_t'(1)) & rmask;
  assign tx_full     = (tx_head_inc == tx_tail_r);
  assign rx_full     = (rx_head_inc == rx_tail_r);
  assign tx_empty    = (tx_head_r == tx_tail_r);
  assign rx_empty    = (rx_head_r == rx_tail_r);
  assign kind        = udrb_pkg::kind_t'(in_kind);

  // Event handling and configuration writes
  always_comb begin
    tx_lg_nxt   = tx_lg_r;
    rx_lg_nxt   = rx_lg_r;
    tx_head_nxt = tx_head_r;
    tx_tail_nxt = tx_tail_r;
    rx_head_nxt = rx_head_r;
    rx_tail_nxt = rx_tail_r;
    tx_irq_nxt  = tx_irq_r;
    pend_nxt    = pend_r;
    tx_we       = 1'b0;
    tx_re       = 1'b0;
    rx_we       = 1'b0;
    rx_re       = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        udrb_pkg::CFG_TX_SIZE: begin
          tx_lg_nxt   = cfg_data;
          tx_head_nxt = '0;
          tx_tail_nxt = '0;
        end
        udrb_pkg::CFG_RX_SIZE: begin
          rx_lg_nxt   = cfg_data;
          rx_head_nxt = '0;
          rx_tail_nxt = '0;
        end
        default: begin
        end
      endcase
    end else if (cmd.accept) begin
      pend_nxt = '0;
      case (kind)
        udrb_pkg::KIND_HOST_WR: begin
          // refuse when full, request transmit either way
          if (tx_full) begin
            pend_nxt.write_refused = 1'b1;
          end else begin
            tx_we       = 1'b1;
            tx_head_nxt = tx_head_inc;
          end
          tx_irq_nxt = 1'b1;
        end
        udrb_pkg::KIND_TX_RDY: begin
          if (!tx_empty) begin
            tx_re             = 1'b1;
            pend_nxt.tx_valid = 1'b1;
            tx_tail_nxt       = (tx_tail_r + ptr_t'(1)) & tmask;
          end else begin
            tx_irq_nxt = 1'b0;
          end
        end
        udrb_pkg::KIND_RX_BYTE: begin
          // drop when full
          if (rx_full) begin
            pend_nxt.rx_dropped = 1'b1;
          end else begin
            rx_we       = 1'b1;
            rx_head_nxt = rx_head_inc;
          end
        end
        udrb_pkg::KIND_HOST_RD: begin
          if (!rx_empty) begin
            rx_re            = 1'b1;
            pend_nxt.read_ok = 1'b1;
            rx_tail_nxt      = (rx_tail_r + ptr_t'(1)) & rmask;
          end
        end
        udrb_pkg::KIND_FLUSH_TX: begin
          tx_head_nxt = '0;
          tx_tail_nxt = '0;
        end
        udrb_pkg::KIND_FLUSH_RX: begin
          rx_head_nxt = '0;
          rx_tail_nxt = '0;
        end
        default: begin
        end
      endcase
      pend_nxt.rx_count   = 7'((rx_head_nxt - rx_tail_nxt) & rmask);
      pend_nxt.tx_request = tx_irq_nxt;
    end
  end

  // Merge store data into the result and drive the output register
  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out) begin
      res_nxt.tx_valid      = pend_r.tx_valid;
      res_nxt.tx_byte       = pend_r.tx_valid ? tx_rdata : 8'd0;
      res_nxt.read_byte     = pend_r.read_ok ? rx_rdata : 8'd0;
      res_nxt.write_refused = pend_r.write_refused;
      res_nxt.rx_dropped    = pend_r.rx_dropped;
      res_nxt.rx_count      = pend_r.rx_count;
      res_nxt.tx_request    = pend_r.tx_request;
      out_valid_nxt         = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_lg_r     <= udrb_pkg::SIZE_LOG2_RESET;
      rx_lg_r     <= udrb_pkg::SIZE_LOG2_RESET;
      tx_head_r   <= '0;
      tx_tail_r   <= '0;
      rx_head_r   <= '0;
      rx_tail_r   <= '0;
      tx_irq_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tx_lg_r     <= tx_lg_nxt;
      rx_lg_r     <= rx_lg_nxt;
      tx_head_r   <= tx_head_nxt;
      tx_tail_r   <= tx_tail_nxt;
      rx_head_r   <= rx_head_nxt;
      rx_tail_r   <= rx_tail_nxt;
      tx_irq_r    <= tx_irq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    res_r  <= res_nxt;
  end

  // Byte stores
  udrb_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_head_r),
    .wdata (in_data_byte),
    .re    (tx_re),
    .raddr (tx_tail_r),
    .rdata (tx_rdata)
  );

  udrb_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_head_r),
    .wdata (in_data_byte),
    .re    (rx_re),
    .raddr (rx_tail_r),
    .rdata (rx_rdata)
  );

  assign status.out_valid = out_valid_r;
  assign out_valid        = out_valid_r;
  assign result           = res_r;

  // Never load over a result that is still waiting
  `UDRB_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.load_out, !out_valid_r || out_ready)
  // A host write always leaves the transmit request set
  `UDRB_ASSERT_NEXT(a_irq_on_write, clk, rst_n,
                    cmd.accept && !cfg_we && kind == udrb_pkg::KIND_HOST_WR, tx_irq_r)
  // Pointers stay inside the configured queue size
  `UDRB_ASSERT_NOW(a_ptr_range, clk, rst_n, 1'b1,
                   ((tx_head_r | tx_tail_r) & ~tmask) == '0 &&
                   ((rx_head_r | rx_tail_r) & ~rmask) == '0)

endmodule

/* design/uart_dual_ring_buffer.sv */
// Serial port ring buffer top level: transmit and receive byte queues.
// Depends on udrb_pkg, udrb_in_if, udrb_out_if, udrb_ctrl and udrb_datapath.
//
// Usage:
//   in_chan carries one event per transfer: host write, transmitter ready,
//   received byte, host read, or a flush of either queue. out_chan returns
//   exactly one result per event, in order.
//   cfg_we/cfg_index/cfg_data set each queue's size as a power of two
//   (index 0 transmit, 1 receive); a write empties that queue. Write only
//   while no event is in flight.
//   An accepted event goes into the pending result register and the store's
//   registered read port; the result is then built in the output register
//   once that is free. No new event is taken before the result is built.
//   The block takes the next event while a finished result still waits,
//   so a stalled receiver costs nothing until a second result is ready;
//   then in_chan.ready stays low until out_chan transfers.
//   Reset: queues empty, both sizes at 128 capped to QUEUE_DEPTH, transmit
//   request off, output empty. Byte stores are not cleared; entries are
//   only read after being written, so no clearing pass is needed.
module uart_dual_ring_buffer #(
  parameter int QUEUE_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [2:0]        cfg_data,
  udrb_in_if.sink           in_chan,
  udrb_out_if.source        out_chan
);

  udrb_pkg::ctrl_cmd_t  cmd;
  udrb_pkg::dp_status_t status;
  udrb_pkg::result_t    result;
  logic                 out_valid;

  // Sequencing
  udrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .in_ready  (in_chan.ready),
    .cmd       (cmd)
  );

  // Queues and result register
  udrb_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_kind      (in_chan.kind),
    .in_data_byte (in_chan.data_byte),
    .cmd          (cmd),
    .out_ready    (out_chan.ready),
    .status       (status),
    .out_valid    (out_valid),
    .result       (result)
  );

  // Drive the result channel
  assign out_chan.valid         = out_valid;
  assign out_chan.tx_valid      = result.tx_valid;
  assign out_chan.tx_byte       = result.tx_byte;
  assign out_chan.read_byte     = result.read_byte;
  assign out_chan.write_refused = result.write_refused;
  assign out_chan.rx_dropped    = result.rx_dropped;
  assign out_chan.rx_count      = result.rx_count;
  assign out_chan.tx_request    = result.tx_request;

endmodule
